// File: design/pidmsr_pkg.sv
// Shared types and constants for the motor speed PID regulator.
`default_nettype none
package pidmsr_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Register indexes (byte address = 4 * index).
	localparam logic [2:0] REG_GAIN_P         = 3'd0;
	localparam logic [2:0] REG_GAIN_I         = 3'd1;
	localparam logic [2:0] REG_GAIN_D         = 3'd2;
	localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd3;
	localparam logic [2:0] REG_PWM_PERIOD     = 3'd4;
	localparam logic [2:0] REG_REVERSE_WIRING = 3'd5;

	localparam logic [23:0] GAIN_P_RST         = 24'd5243;
	localparam logic [23:0] GAIN_I_RST         = 24'd1049;
	localparam logic [23:0] GAIN_D_RST         = 24'd1049;
	localparam logic [15:0] INTEGRAL_LIMIT_RST = 16'd1000;
	localparam logic [15:0] PWM_PERIOD_RST     = 16'd750;

	localparam int Q20_SHIFT = 20;
	localparam logic signed [44:0] ONE_Q20 = 45'sd1048576;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MULP,
		ST_MULI,
		ST_MULD,
		ST_ADDD,
		ST_SAT,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_P,
		MUL_I,
		MUL_D,
		MUL_CMP
	} mul_sel_t;

	typedef struct packed {
		logic [23:0] gain_p;
		logic [23:0] gain_i;
		logic [23:0] gain_d;
		logic [15:0] integral_limit;
		logic [15:0] pwm_period;
		logic        reverse_wiring;
	} cfg_t;

	typedef struct packed {
		logic     load_in;
		logic     calc_err;
		logic     clr_sum;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_en;
		logic     calc_sat;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic target_zero;
	} status_t;

endpackage
`default_nettype wire

// File: design/pid_motor_speed_pwm_regulator_core.sv
// Top level of the motor speed PID regulator: register port, sequencer and datapath.
//
//  channel   direction  handshake            payload
//  in        input      in_valid/in_stall    target_rate, measured_rate
//  out       output     out_valid/out_stall  compare_forward, compare_reverse, reverse_direction
//  cfg       input      APB psel/penable     paddr, pwdata, prdata
//
// An item goes from acceptance to a valid result through the sequencer, which runs the error
// step, three gain products on the one shared multiplier, their sum, the drive clamp and the
// compare product in turn; a zero target skips the gain products and their sum. The next item
// can be taken in the cycle after the result is loaded, not before.
// Input is taken only while the sequencer is idle; a result waiting on out_stall does not
// block the next item until that item is ready to be written out.
// Reset clears the PID state, the handshake state and restores the register defaults.
`default_nettype none
module pid_motor_speed_pwm_regulator_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire signed [15:0]            target_rate,
	input  wire signed [15:0]            measured_rate,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [15:0]                  compare_forward,
	output logic [15:0]                  compare_reverse,
	output logic                         reverse_direction,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [pidmsr_pkg::ADDR_W-1:0] paddr,
	input  wire [pidmsr_pkg::DATA_W-1:0] pwdata,
	output logic [pidmsr_pkg::DATA_W-1:0] prdata,
	output logic                         pready
);

	pidmsr_pkg::cfg_t    cfg_q;
	pidmsr_pkg::cmd_t    cmd;
	pidmsr_pkg::status_t status;
	logic [2:0]          reg_idx;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= pidmsr_pkg::GAIN_P_RST;
			cfg_q.gain_i         <= pidmsr_pkg::GAIN_I_RST;
			cfg_q.gain_d         <= pidmsr_pkg::GAIN_D_RST;
			cfg_q.integral_limit <= pidmsr_pkg::INTEGRAL_LIMIT_RST;
			cfg_q.pwm_period     <= pidmsr_pkg::PWM_PERIOD_RST;
			cfg_q.reverse_wiring <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				pidmsr_pkg::REG_GAIN_P:         cfg_q.gain_p         <= pwdata[23:0];
				pidmsr_pkg::REG_GAIN_I:         cfg_q.gain_i         <= pwdata[23:0];
				pidmsr_pkg::REG_GAIN_D:         cfg_q.gain_d         <= pwdata[23:0];
				pidmsr_pkg::REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= pwdata[15:0];
				pidmsr_pkg::REG_PWM_PERIOD:     cfg_q.pwm_period     <= pwdata[15:0];
				pidmsr_pkg::REG_REVERSE_WIRING: cfg_q.reverse_wiring <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pidmsr_pkg::REG_GAIN_P:         prdata = {8'd0, cfg_q.gain_p};
			pidmsr_pkg::REG_GAIN_I:         prdata = {8'd0, cfg_q.gain_i};
			pidmsr_pkg::REG_GAIN_D:         prdata = {8'd0, cfg_q.gain_d};
			pidmsr_pkg::REG_INTEGRAL_LIMIT: prdata = {16'd0, cfg_q.integral_limit};
			pidmsr_pkg::REG_PWM_PERIOD:     prdata = {16'd0, cfg_q.pwm_period};
			pidmsr_pkg::REG_REVERSE_WIRING: prdata = {31'd0, cfg_q.reverse_wiring};
			default:                        prdata = '0;
		endcase
	end

	pidmsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	pidmsr_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg               (cfg_q),
		.target_rate       (target_rate),
		.measured_rate     (measured_rate),
		.compare_forward   (compare_forward),
		.compare_reverse   (compare_reverse),
		.reverse_direction (reverse_direction)
	);

endmodule
`default_nettype wire

// File: design/pidmsr_ctrl.sv
// Sequencer for one regulator tick: accept, error step, shared multiplies, output.
`default_nettype none
module pidmsr_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire                  out_stall,
	input  pidmsr_pkg::status_t  status,
	output pidmsr_pkg::cmd_t     cmd
);

	pidmsr_pkg::state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pidmsr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = pidmsr_pkg::MUL_P;
		in_stall    = 1'b1;
		case (state_q)
			pidmsr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = pidmsr_pkg::ST_ERR;
				end
			end
			pidmsr_pkg::ST_ERR: begin
				cmd.calc_err = 1'b1;
				cmd.clr_sum  = 1'b1;
				// zero target skips the weighted sum and drives zero
				state_d = status.target_zero ? pidmsr_pkg::ST_SAT : pidmsr_pkg::ST_MULP;
			end
			pidmsr_pkg::ST_MULP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pidmsr_pkg::MUL_P;
				state_d     = pidmsr_pkg::ST_MULI;
			end
			pidmsr_pkg::ST_MULI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pidmsr_pkg::MUL_I;
				cmd.acc_en  = 1'b1;
				state_d     = pidmsr_pkg::ST_MULD;
			end
			pidmsr_pkg::ST_MULD: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pidmsr_pkg::MUL_D;
				cmd.acc_en  = 1'b1;
				state_d     = pidmsr_pkg::ST_ADDD;
			end
			pidmsr_pkg::ST_ADDD: begin
				cmd.acc_en = 1'b1;
				state_d    = pidmsr_pkg::ST_SAT;
			end
			pidmsr_pkg::ST_SAT: begin
				cmd.calc_sat = 1'b1;
				state_d      = pidmsr_pkg::ST_CMP;
			end
			pidmsr_pkg::ST_CMP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pidmsr_pkg::MUL_CMP;
				state_d     = pidmsr_pkg::ST_DONE;
			end
			pidmsr_pkg::ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = pidmsr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pidmsr_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: design/pidmsr_datapath.sv
// Regulator datapath: PID state, one shared multiplier, drive clamp and compare mapping.
`default_nettype none
module pidmsr_datapath (
	input  wire                         clk,
	input  wire                         arst_n,
	input  pidmsr_pkg::cmd_t            cmd,
	output pidmsr_pkg::status_t         status,
	input  pidmsr_pkg::cfg_t            cfg,
	input  wire signed [15:0]           target_rate,
	input  wire signed [15:0]           measured_rate,
	output logic [15:0]                 compare_forward,
	output logic [15:0]                 compare_reverse,
	output logic                        reverse_direction
);

	logic signed [15:0] target_q;
	logic signed [15:0] measured_q;
	logic signed [15:0] prev_error_q;
	logic signed [16:0] integral_q;
	logic signed [15:0] prev_target_q;

	logic signed [15:0] err_q;
	logic signed [16:0] deriv_q;
	logic signed [16:0] acc_q;
	logic signed [46:0] prod_q;
	logic signed [43:0] sum_q;
	logic        [20:0] mag_q;
	logic               neg_q;

	logic signed [16:0] diff;
	logic signed [15:0] err_sat;
	logic signed [16:0] deriv;
	logic signed [16:0] base;
	logic signed [17:0] acc_raw;
	logic signed [17:0] lim_pos;
	logic signed [17:0] lim_neg;
	logic signed [17:0] acc_clamp;

	logic signed [21:0] mul_a;
	logic signed [24:0] mul_b;

	logic               keep;
	logic signed [44:0] drv_keep;
	logic signed [44:0] drv_inv;
	logic signed [44:0] drv_clamp;
	logic signed [44:0] drv_mag;
	logic        [15:0] cmp_val;

	always_comb begin
		diff = {target_q[15], target_q} - {measured_q[15], measured_q};
		if (diff > 17'sd32767) begin
			err_sat = 16'sh7fff;
		end else if (diff < -17'sd32768) begin
			err_sat = -16'sd32768;
		end else begin
			err_sat = diff[15:0];
		end
		deriv = {err_sat[15], err_sat} - {prev_error_q[15], prev_error_q};
		// a changed target starts the integral from zero
		base    = (target_q != prev_target_q) ? 17'sd0 : integral_q;
		acc_raw = {base[16], base} + {{2{err_sat[15]}}, err_sat};
		lim_pos = {2'b00, cfg.integral_limit};
		lim_neg = -lim_pos;
		if (acc_raw > lim_pos) begin
			acc_clamp = lim_pos;
		end else if (acc_raw < lim_neg) begin
			acc_clamp = lim_neg;
		end else begin
			acc_clamp = acc_raw;
		end
	end

	always_comb begin
		case (cmd.mul_sel)
			pidmsr_pkg::MUL_P: begin
				mul_a = {{6{err_q[15]}}, err_q};
				mul_b = {1'b0, cfg.gain_p};
			end
			pidmsr_pkg::MUL_I: begin
				mul_a = {{5{acc_q[16]}}, acc_q};
				mul_b = {1'b0, cfg.gain_i};
			end
			pidmsr_pkg::MUL_D: begin
				mul_a = {{5{deriv_q[16]}}, deriv_q};
				mul_b = {1'b0, cfg.gain_d};
			end
			pidmsr_pkg::MUL_CMP: begin
				mul_a = {1'b0, mag_q};
				mul_b = {9'd0, cfg.pwm_period};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		keep = ((sum_q > 44'sd0) && (target_q > 16'sd0)) ||
		       ((sum_q < 44'sd0) && (target_q < 16'sd0));
		drv_keep = keep ? {sum_q[43], sum_q} : 45'sd0;
		drv_inv  = cfg.reverse_wiring ? -drv_keep : drv_keep;
		if (drv_inv > pidmsr_pkg::ONE_Q20) begin
			drv_clamp = pidmsr_pkg::ONE_Q20;
		end else if (drv_inv < -pidmsr_pkg::ONE_Q20) begin
			drv_clamp = -pidmsr_pkg::ONE_Q20;
		end else begin
			drv_clamp = drv_inv;
		end
		drv_mag = drv_clamp[44] ? -drv_clamp : drv_clamp;
		cmp_val = prod_q[pidmsr_pkg::Q20_SHIFT +: 16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q  <= '0;
			integral_q    <= '0;
			prev_target_q <= '0;
		end else if (cmd.calc_err) begin
			if (target_q == 16'sd0) begin
				integral_q <= '0;
			end else begin
				prev_target_q <= target_q;
				prev_error_q  <= err_sat;
				integral_q    <= acc_clamp[16:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			target_q   <= target_rate;
			measured_q <= measured_rate;
		end
		if (cmd.calc_err) begin
			err_q   <= err_sat;
			deriv_q <= deriv;
			acc_q   <= acc_clamp[16:0];
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.clr_sum) begin
			sum_q <= '0;
		end else if (cmd.acc_en) begin
			sum_q <= sum_q + prod_q[43:0];
		end
		if (cmd.calc_sat) begin
			neg_q <= drv_clamp[44];
			mag_q <= drv_mag[20:0];
		end
		if (cmd.out_load) begin
			compare_forward   <= neg_q ? 16'd0 : cmp_val;
			compare_reverse   <= neg_q ? cmp_val : 16'd0;
			reverse_direction <= neg_q ? !cfg.reverse_wiring : cfg.reverse_wiring;
		end
	end

	assign status.target_zero = (target_q == 16'sd0);

endmodule
`default_nettype wire

// File: test/pid_motor_speed_pwm_regulator_core_tb.sv
// Self-checking testbench for the motor speed PID regulator core.
`default_nettype none
module pid_motor_speed_pwm_regulator_core_tb;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_PER_SETTING = 150;

	typedef struct {
		logic signed [15:0] target;
		logic signed [15:0] measured;
	} tick_t;

	typedef struct {
		logic [15:0] fwd;
		logic [15:0] rev;
		logic        dir;
	} pwm_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] target_rate = '0;
	logic signed [15:0] measured_rate = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] compare_forward;
	logic [15:0] compare_reverse;
	logic reverse_direction;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [pidmsr_pkg::ADDR_W-1:0] paddr = '0;
	logic [pidmsr_pkg::DATA_W-1:0] pwdata = '0;
	logic [pidmsr_pkg::DATA_W-1:0] prdata;
	logic pready;

	pid_motor_speed_pwm_regulator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.target_rate(target_rate),
		.measured_rate(measured_rate),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.compare_forward(compare_forward),
		.compare_reverse(compare_reverse),
		.reverse_direction(reverse_direction),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tick_t pending_ticks[$];
	pwm_result_t expected_pwm[$];
	tick_t next_tick;
	int idle_mode = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	// Regulator state and register copies
	pidmsr_pkg::cfg_t model_cfg;
	logic signed [15:0] last_error;
	logic signed [16:0] integral_sum;
	logic signed [15:0] last_target;

	function automatic pwm_result_t predict_tick(input logic signed [15:0] tgt,
			input logic signed [15:0] meas);
		int err;
		int deriv;
		int acc;
		int lim;
		longint drive;
		longint mag;
		longint cmp;
		longint one;
		pwm_result_t res;
		one = longint'(1) << pidmsr_pkg::Q20_SHIFT;
		if (tgt == 0) begin
			integral_sum = '0;
			drive = 0;
		end else begin
			if (tgt != last_target) begin
				integral_sum = '0;
				last_target = tgt;
			end
			err = int'(tgt) - int'(meas);
			if (err > 32767) err = 32767;
			if (err < -32768) err = -32768;
			deriv = err - int'(last_error);
			last_error = err[15:0];
			lim = int'(model_cfg.integral_limit);
			acc = int'(integral_sum) + err;
			if (acc > lim)
				acc = lim;
			else if (acc < -lim)
				acc = -lim;
			integral_sum = acc[16:0];
			drive = longint'(err) * longint'(model_cfg.gain_p)
				+ longint'(acc) * longint'(model_cfg.gain_i)
				+ longint'(deriv) * longint'(model_cfg.gain_d);
			// drop drive that pushes against the commanded direction
			if (!((drive > 0 && tgt > 0) || (drive < 0 && tgt < 0)))
				drive = 0;
		end
		if (model_cfg.reverse_wiring)
			drive = -drive;
		if (drive > one) drive = one;
		if (drive < -one) drive = -one;
		mag = (drive < 0) ? -drive : drive;
		cmp = (mag * longint'(model_cfg.pwm_period)) >>> pidmsr_pkg::Q20_SHIFT;
		if (drive < 0) begin
			res.fwd = '0;
			res.rev = cmp[15:0];
			res.dir = !model_cfg.reverse_wiring;
		end else begin
			res.fwd = cmp[15:0];
			res.rev = '0;
			res.dir = model_cfg.reverse_wiring;
		end
		return res;
	endfunction

	// Driver: present queued items, hold each one until accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_pwm.push_back(predict_tick(target_rate, measured_rate));
			if (!in_valid || !in_stall) begin
				if (pending_ticks.size() != 0 &&
						$urandom_range(99) >= ((idle_mode == 0) ? 8 : (idle_mode == 1) ? 48 : 0)) begin
					next_tick = pending_ticks.pop_front();
					in_valid <= 1'b1;
					target_rate <= next_tick.target;
					measured_rate <= next_tick.measured;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random and check each accepted result
	always @(posedge clk) begin
		pwm_result_t exp_res;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_pwm.size() == 0) begin
					$error("result with no item pending: fwd %0d rev %0d dir %0d",
						compare_forward, compare_reverse, reverse_direction);
					fail_count++;
				end else begin
					exp_res = expected_pwm.pop_front();
					if (compare_forward !== exp_res.fwd) begin
						$error("compare_forward: expected %0d, actual %0d",
							exp_res.fwd, compare_forward);
						fail_count++;
					end
					if (compare_reverse !== exp_res.rev) begin
						$error("compare_reverse: expected %0d, actual %0d",
							exp_res.rev, compare_reverse);
						fail_count++;
					end
					if (reverse_direction !== exp_res.dir) begin
						$error("reverse_direction: expected %0d, actual %0d",
							exp_res.dir, reverse_direction);
						fail_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) <
				((idle_mode == 0) ? 48 : (idle_mode == 1) ? 8 : 0));
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("pid_motor_speed_pwm_regulator_core regression: fail");
			$finish;
		end
	end

	function automatic void add_tick(input int tgt, input int meas);
		tick_t tk;
		tk.target = tgt[15:0];
		tk.measured = meas[15:0];
		pending_ticks.push_back(tk);
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			pidmsr_pkg::REG_GAIN_P:         model_cfg.gain_p = value[23:0];
			pidmsr_pkg::REG_GAIN_I:         model_cfg.gain_i = value[23:0];
			pidmsr_pkg::REG_GAIN_D:         model_cfg.gain_d = value[23:0];
			pidmsr_pkg::REG_INTEGRAL_LIMIT: model_cfg.integral_limit = value[15:0];
			pidmsr_pkg::REG_PWM_PERIOD:     model_cfg.pwm_period = value[15:0];
			pidmsr_pkg::REG_REVERSE_WIRING: model_cfg.reverse_wiring = value[0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [23:0] gp, input logic [23:0] gi,
			input logic [23:0] gd, input logic [15:0] lim, input logic [15:0] period,
			input logic rev);
		write_reg(pidmsr_pkg::REG_GAIN_P, {8'd0, gp});
		write_reg(pidmsr_pkg::REG_GAIN_I, {8'd0, gi});
		write_reg(pidmsr_pkg::REG_GAIN_D, {8'd0, gd});
		write_reg(pidmsr_pkg::REG_INTEGRAL_LIMIT, {16'd0, lim});
		write_reg(pidmsr_pkg::REG_PWM_PERIOD, {16'd0, period});
		write_reg(pidmsr_pkg::REG_REVERSE_WIRING, {31'd0, rev});
	endtask

	// Mostly runs of one target with the measured rate near it, plus noise
	task automatic queue_random_ticks(input int count);
		int n;
		int run_len;
		int span;
		int tgt;
		int meas;
		n = 0;
		while (n < count) begin
			if ($urandom_range(9) < 3) begin
				add_tick(int'($urandom), int'($urandom));
				n++;
			end else begin
				case ($urandom_range(3))
					0: tgt = int'($urandom_range(65535)) - 32768;
					1: tgt = int'($urandom_range(4000)) - 2000;
					2: tgt = 0;
					default: tgt = $urandom_range(1) ? 32767 : -32768;
				endcase
				run_len = $urandom_range(12, 3);
				span = 1 << $urandom_range(14);
				repeat (run_len) begin
					meas = tgt + int'($urandom_range(2 * span)) - span;
					if (meas > 32767) meas = 32767;
					if (meas < -32768) meas = -32768;
					add_tick(tgt, meas);
				end
				n += run_len;
			end
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_ticks.size() != 0 || in_valid || expected_pwm.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		model_cfg.gain_p = pidmsr_pkg::GAIN_P_RST;
		model_cfg.gain_i = pidmsr_pkg::GAIN_I_RST;
		model_cfg.gain_d = pidmsr_pkg::GAIN_D_RST;
		model_cfg.integral_limit = pidmsr_pkg::INTEGRAL_LIMIT_RST;
		model_cfg.pwm_period = pidmsr_pkg::PWM_PERIOD_RST;
		model_cfg.reverse_wiring = 1'b0;
		last_error = '0;
		integral_sum = '0;
		last_target = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// zero target, with and without a measured rate
		add_tick(0, 0);
		add_tick(0, 12345);
		// error saturation both ways, then zero error at both extremes
		add_tick(32767, -32768);
		add_tick(-32768, 32767);
		add_tick(-32768, -32768);
		add_tick(32767, 32767);
		// changed target, then integral build-up on a held target
		add_tick(100, 100);
		add_tick(100, 50);
		add_tick(100, 50);
		add_tick(100, 50);
		// drive against the target sign is zeroed
		add_tick(100, 200);
		add_tick(-100, -50);
		add_tick(-100, -150);
		// integral clamp at the positive and negative bound
		add_tick(1000, 0);
		add_tick(1000, 0);
		add_tick(1000, 0);
		add_tick(-1000, 0);
		add_tick(-1000, 0);
		add_tick(-1000, 0);
		// zero target clears the integral but keeps the target history
		add_tick(0, -500);
		add_tick(-1000, 0);
		add_tick(1, 0);
		add_tick(-1, 0);
		wait_drained();

		for (int setting = 0; setting < 6; setting++) begin
			idle_mode = setting / 2;
			case (setting)
				0: program_regs(pidmsr_pkg::GAIN_P_RST, pidmsr_pkg::GAIN_I_RST,
					pidmsr_pkg::GAIN_D_RST, pidmsr_pkg::INTEGRAL_LIMIT_RST,
					pidmsr_pkg::PWM_PERIOD_RST, 1'b1);
				1: program_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
				2: program_regs(24'd0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b1);
				3: program_regs(24'($urandom_range(1 << 20)), 24'($urandom_range(1 << 17)),
					24'($urandom_range(1 << 17)), 16'($urandom_range(4000)),
					16'($urandom_range(65535)), 1'($urandom_range(1)));
				4: program_regs(24'd256, 24'd64, 24'd32, 16'd1, 16'hFFFF, 1'b0);
				default: program_regs(24'($urandom), 24'($urandom), 24'($urandom),
					16'($urandom), 16'($urandom), 1'($urandom));
			endcase
			queue_random_ticks(RANDOM_PER_SETTING);
			wait_drained();
		end

		if (fail_count == 0)
			$display("pid_motor_speed_pwm_regulator_core regression: pass");
		else
			$display("pid_motor_speed_pwm_regulator_core regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
